// ===== rtl/trpd_pkg.sv =====
// Shared types and constants of the trace ring page decoder.
package trpd_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DELTA_BITS = 27;
    localparam int TL_W       = 5;

    localparam logic [TL_W-1:0] TYPE_DATA_MAX    = 5'd28;
    localparam logic [TL_W-1:0] TYPE_PADDING     = 5'd29;
    localparam logic [TL_W-1:0] TYPE_TIME_EXTEND = 5'd30;

    localparam logic [CFG_IDX_W-1:0] CFG_CPU_ID      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_ID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_ID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKEUP_ID   = 3'd4;

    localparam logic [15:0] EXIT_ID_RESET   = 16'd16;
    localparam logic [15:0] ENTER_ID_RESET  = 16'd17;
    localparam logic [15:0] SWITCH_ID_RESET = 16'd273;
    localparam logic [15:0] WAKEUP_ID_RESET = 16'd275;

    // expected payload sizes in bytes
    localparam logic [31:0] LEN_EXIT    = 32'd24;
    localparam logic [31:0] LEN_ENTER   = 32'd64;
    localparam logic [31:0] LEN_SWITCH  = 32'd64;
    localparam logic [31:0] LEN_WAKEUP  = 32'd40;
    localparam logic [31:0] LEN_UNKNOWN = 32'd8;

    // payload word positions
    localparam logic [4:0] PW_TYPE       = 5'd0;
    localparam logic [4:0] PW_PID        = 5'd1;
    localparam logic [4:0] PW_NUM_LO     = 5'd2;
    localparam logic [4:0] PW_NUM_HI     = 5'd3;
    localparam logic [4:0] PW_PREV_PID   = 5'd6;
    localparam logic [4:0] PW_STATE_LO   = 5'd8;
    localparam logic [4:0] PW_STATE_HI   = 5'd9;
    localparam logic [4:0] PW_NEXT_PID   = 5'd14;
    localparam logic [4:0] PW_LAST       = 5'd31;

    typedef enum logic [2:0] {
        KIND_EXIT    = 3'd0,
        KIND_ENTER   = 3'd1,
        KIND_SWITCH  = 3'd2,
        KIND_WAKEUP  = 3'd3,
        KIND_UNKNOWN = 3'd4,
        KIND_INVALID = 3'd5
    } kind_t;

    typedef struct packed {
        logic [63:0]        timestamp_ns;
        logic [7:0]         ring_cpu;
        kind_t              event_kind;
        logic               length_ok;
        logic signed [31:0] event_pid;
        logic signed [63:0] syscall_number;
        logic signed [31:0] previous_pid;
        logic               previous_running;
        logic signed [31:0] incoming_pid;
        logic signed [31:0] woken_pid;
        logic signed [31:0] wake_target_cpu;
    } result_t;

    typedef struct packed {
        logic [15:0] ev_type;
        logic [31:0] pid;
        logic [63:0] number;
        logic [31:0] outgoing_pid;
        logic        prev_zero;
        logic [31:0] incoming_pid;
        logic [31:0] woken_pid;
        logic [31:0] target;
    } held_t;

endpackage

// ===== rtl/trpd_if.sv =====
// Request channel interfaces for page words and decoded results.
interface trpd_page_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        page_start;

    modport source (output valid, output word, output page_start, input ready);
    modport sink (input valid, input word, input page_start, output ready);
endinterface

interface trpd_result_if;
    logic               valid;
    logic               ready;
    logic [63:0]        timestamp_ns;
    logic [7:0]         ring_cpu;
    logic [2:0]         event_kind;
    logic               length_ok;
    logic signed [31:0] event_pid;
    logic signed [63:0] syscall_number;
    logic signed [31:0] previous_pid;
    logic               previous_running;
    logic signed [31:0] incoming_pid;
    logic signed [31:0] woken_pid;
    logic signed [31:0] wake_target_cpu;

    modport source (
        output valid, input ready,
        output timestamp_ns, output ring_cpu, output event_kind, output length_ok,
        output event_pid, output syscall_number, output previous_pid,
        output previous_running, output incoming_pid, output woken_pid,
        output wake_target_cpu
    );
    modport sink (
        input valid, output ready,
        input timestamp_ns, input ring_cpu, input event_kind, input length_ok,
        input event_pid, input syscall_number, input previous_pid,
        input previous_running, input incoming_pid, input woken_pid,
        input wake_target_cpu
    );
endinterface

// ===== rtl/trace_ring_page_decoder_unit.sv =====
// Trace ring page decoder: header parse, record decode, result buffer.
// A result is written to the result buffer when the request word that completes it is accepted.
// Throughput: one word per cycle; the decode state update is a single pass with one
// 64-bit timestamp adder, and a two-entry result buffer keeps input flowing while
// the consumer stalls (input stops only when both entries are full).
// Reset: asynchronous, active low; waits for page start, registers take defaults.
module trace_ring_page_decoder_unit
    import trpd_pkg::*;
#(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_enable,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DATA_W-1:0] write_data,
    trpd_page_if.sink             page,
    trpd_result_if.source         result
);

    localparam int POS_W = $clog2(PAGE_BYTES) + 1;
    localparam logic [POS_W-1:0] DATA_MAX = POS_W'(PAGE_BYTES - 16);
    localparam logic [31:0]      DATA_MAX_W = 32'(PAGE_BYTES - 16);

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_HEADER   = 8'b0000_0010,
        PH_REC      = 8'b0000_0100,
        PH_LEN_DATA = 8'b0000_1000,
        PH_LEN_PAD  = 8'b0001_0000,
        PH_EXTEND   = 8'b0010_0000,
        PH_PAYLOAD  = 8'b0100_0000,
        PH_SKIP     = 8'b1000_0000
    } phase_t;

    // configuration
    logic [7:0]  cpu_id_reg;
    logic [15:0] exit_id_reg, enter_id_reg, switch_id_reg, wakeup_id_reg;

    // decode state
    phase_t           phase_reg, phase_next;
    logic [1:0]       hdr_idx_reg, hdr_idx_next;
    logic [POS_W-1:0] pdb_reg, pdb_next;
    logic [POS_W-1:0] bp_reg, bp_next;
    logic [63:0]      time_reg, time_next;
    logic [26:0]      pending_reg, pending_next;
    logic [31:0]      left_reg, left_next;
    logic [4:0]       pwi_reg, pwi_next;
    logic [31:0]      rec_len_reg, rec_len_next;
    held_t            held_reg, held_next;

    // result buffer
    result_t    buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    logic       in_acc, push, pop, emit, emit_invalid, data_phase;
    result_t    new_res;
    logic [63:0] addend;
    logic        add_en;
    logic [4:0]  tl;
    logic [26:0] delta;
    logic [POS_W-1:0] avail;
    logic [2:0]  valid_bytes;
    logic [31:0] mw;
    logic [31:0] len_w;

    function automatic logic [2:0] take_four(input logic [31:0] left);
        return (left < 32'd4) ? left[2:0] : 3'd4;
    endfunction

    function automatic result_t build_record(
        input held_t       h,
        input logic [31:0] len,
        input logic [63:0] ts,
        input logic [7:0]  cpu,
        input logic [15:0] exit_id,
        input logic [15:0] enter_id,
        input logic [15:0] switch_id,
        input logic [15:0] wakeup_id
    );
        result_t r;
        r = '0;
        r.timestamp_ns = ts;
        r.ring_cpu     = cpu;
        r.event_pid    = h.pid;
        priority if (h.ev_type == exit_id)
        begin
            r.event_kind     = KIND_EXIT;
            r.length_ok      = (len == LEN_EXIT);
            r.syscall_number = h.number;
        end
        else if (h.ev_type == enter_id)
        begin
            r.event_kind     = KIND_ENTER;
            r.length_ok      = (len == LEN_ENTER);
            r.syscall_number = h.number;
        end
        else if (h.ev_type == switch_id)
        begin
            r.event_kind       = KIND_SWITCH;
            r.length_ok        = (len == LEN_SWITCH);
            r.previous_pid     = h.outgoing_pid;
            r.previous_running = h.prev_zero;
            r.incoming_pid     = h.incoming_pid;
        end
        else if (h.ev_type == wakeup_id)
        begin
            r.event_kind      = KIND_WAKEUP;
            r.length_ok       = (len == LEN_WAKEUP);
            r.woken_pid       = h.woken_pid;
            r.wake_target_cpu = h.target;
        end
        else
        begin
            r.event_kind = KIND_UNKNOWN;
            r.length_ok  = (len == LEN_UNKNOWN);
        end
        return r;
    endfunction

    assign in_acc     = page.valid && page.ready;
    assign page.ready = (count_reg != 2'd2);
    assign data_phase = (phase_reg != PH_IDLE) && (phase_reg != PH_HEADER);
    assign tl         = page.word[TL_W-1:0];
    assign delta      = page.word[31:5];
    assign avail      = (pdb_reg > bp_reg) ? (pdb_reg - bp_reg) : '0;
    assign len_w      = (page.word >= 32'd4) ? (page.word - 32'd4) : 32'd0;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        pdb_next     = pdb_reg;
        bp_next      = bp_reg;
        pending_next = pending_reg;
        left_next    = left_reg;
        pwi_next     = pwi_reg;
        rec_len_next = rec_len_reg;
        held_next    = held_reg;
        emit         = 1'b0;
        emit_invalid = 1'b0;
        addend       = '0;
        add_en       = 1'b0;
        valid_bytes  = '0;
        mw           = '0;

        // the data record start below is shared by inline and explicit length records
        if (in_acc && !page.page_start && data_phase)
        begin
            unique case (phase_reg)
                PH_REC:
                begin
                    priority if (tl == '0)
                    begin
                        pending_next = delta;
                        phase_next   = PH_LEN_DATA;
                    end
                    else if (tl <= TYPE_DATA_MAX)
                    begin
                        addend = {37'b0, delta};
                        add_en = 1'b1;
                    end
                    else if (tl == TYPE_PADDING)
                    begin
                        if (delta == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            pending_next = delta;
                            phase_next   = PH_LEN_PAD;
                        end
                    end
                    else if (tl == TYPE_TIME_EXTEND)
                    begin
                        pending_next = delta;
                        phase_next   = PH_EXTEND;
                    end
                    else
                    begin
                        emit         = 1'b1;
                        emit_invalid = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                end
                PH_LEN_DATA:
                begin
                    addend = {37'b0, pending_reg};
                    add_en = 1'b1;
                end
                PH_LEN_PAD:
                begin
                    addend     = {37'b0, pending_reg};
                    add_en     = 1'b1;
                    left_next  = len_w;
                    phase_next = (len_w != '0) ? PH_SKIP : PH_REC;
                end
                PH_EXTEND:
                begin
                    addend     = {5'b0, page.word, pending_reg};
                    add_en     = 1'b1;
                    phase_next = PH_REC;
                end
                PH_SKIP:
                begin
                    left_next = left_reg - 32'(take_four(left_reg));
                    if (left_next == '0)
                    begin
                        phase_next = PH_REC;
                    end
                end
                PH_PAYLOAD:
                begin
                    valid_bytes = take_four(left_reg);
                    if (avail < POS_W'(valid_bytes))
                    begin
                        valid_bytes = avail[2:0];
                    end
                    unique case (valid_bytes)
                        3'd0:    mw = '0;
                        3'd1:    mw = {24'b0, page.word[7:0]};
                        3'd2:    mw = {16'b0, page.word[15:0]};
                        3'd3:    mw = {8'b0, page.word[23:0]};
                        default: mw = page.word;
                    endcase
                    unique case (pwi_reg)
                        PW_TYPE:     held_next.ev_type = mw[15:0];
                        PW_PID:      held_next.pid = mw;
                        PW_NUM_LO:   held_next.number[31:0] = mw;
                        PW_NUM_HI:   held_next.number[63:32] = mw;
                        PW_PREV_PID:
                        begin
                            held_next.outgoing_pid = mw;
                            held_next.woken_pid    = mw;
                        end
                        PW_STATE_LO: held_next.prev_zero = held_reg.prev_zero && (mw == '0);
                        PW_STATE_HI:
                        begin
                            held_next.prev_zero = held_reg.prev_zero && (mw == '0);
                            held_next.target    = mw;
                        end
                        PW_NEXT_PID: held_next.incoming_pid = mw;
                        default:     ;
                    endcase
                    left_next = left_reg - 32'(take_four(left_reg));
                    if (pwi_reg != PW_LAST)
                    begin
                        pwi_next = pwi_reg + 5'd1;
                    end
                    if (left_next == '0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_REC;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase

            // start of a data record
            if ((phase_reg == PH_REC && tl != '0 && tl <= TYPE_DATA_MAX) ||
                phase_reg == PH_LEN_DATA)
            begin
                held_next           = '0;
                held_next.prev_zero = 1'b1;
                pwi_next            = '0;
                rec_len_next        = (phase_reg == PH_REC) ? {25'b0, tl, 2'b00} : len_w;
                left_next           = rec_len_next;
                if (rec_len_next == '0)
                begin
                    emit       = 1'b1;
                    phase_next = PH_REC;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end

            bp_next = bp_reg + POS_W'(4);
            if (phase_next != PH_IDLE && bp_next >= pdb_reg)
            begin
                if (phase_next == PH_PAYLOAD && !emit)
                begin
                    emit = 1'b1;
                end
                phase_next = PH_IDLE;
            end
        end
        else if (in_acc && page.page_start)
        begin
            hdr_idx_next = 2'd1;
            phase_next   = PH_HEADER;
        end
        else if (in_acc && phase_reg == PH_HEADER)
        begin
            unique case (hdr_idx_reg)
                2'd1:    ;
                2'd2:    pdb_next = (page.word < DATA_MAX_W) ? page.word[POS_W-1:0] : DATA_MAX;
                default:
                begin
                    if (page.word != '0)
                    begin
                        pdb_next = DATA_MAX;
                    end
                    bp_next    = '0;
                    phase_next = (pdb_next != '0) ? PH_REC : PH_IDLE;
                end
            endcase
            hdr_idx_next = hdr_idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        time_next = time_reg;
        if (in_acc && page.page_start)
        begin
            time_next = {32'b0, page.word};
        end
        else if (in_acc && phase_reg == PH_HEADER && hdr_idx_reg == 2'd1)
        begin
            time_next = {page.word, time_reg[31:0]};
        end
        else if (add_en)
        begin
            time_next = time_reg + addend;
        end
    end

    always_comb
    begin
        if (emit_invalid)
        begin
            new_res              = '0;
            new_res.timestamp_ns = time_reg;
            new_res.ring_cpu     = cpu_id_reg;
            new_res.event_kind   = KIND_INVALID;
        end
        else
        begin
            new_res = build_record(held_next, rec_len_next, time_next, cpu_id_reg,
                                   exit_id_reg, enter_id_reg, switch_id_reg,
                                   wakeup_id_reg);
        end
    end

    assign push = emit;
    assign pop  = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_id_reg    <= '0;
            exit_id_reg   <= EXIT_ID_RESET;
            enter_id_reg  <= ENTER_ID_RESET;
            switch_id_reg <= SWITCH_ID_RESET;
            wakeup_id_reg <= WAKEUP_ID_RESET;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                CFG_CPU_ID:    cpu_id_reg    <= write_data[7:0];
                CFG_EXIT_ID:   exit_id_reg   <= write_data;
                CFG_ENTER_ID:  enter_id_reg  <= write_data;
                CFG_SWITCH_ID: switch_id_reg <= write_data;
                CFG_WAKEUP_ID: wakeup_id_reg <= write_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hdr_idx_reg <= '0;
            pdb_reg     <= '0;
            bp_reg      <= '0;
            time_reg    <= '0;
            pending_reg <= '0;
            left_reg    <= '0;
            pwi_reg     <= '0;
            rec_len_reg <= '0;
            held_reg    <= '0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            pdb_reg     <= pdb_next;
            bp_reg      <= bp_next;
            time_reg    <= time_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
            pwi_reg     <= pwi_next;
            rec_len_reg <= rec_len_next;
            held_reg    <= held_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= new_res;
        end
    end

    assign result.valid            = (count_reg != 2'd0);
    assign result.timestamp_ns     = buf_reg[rd_ptr_reg].timestamp_ns;
    assign result.ring_cpu         = buf_reg[rd_ptr_reg].ring_cpu;
    assign result.event_kind       = buf_reg[rd_ptr_reg].event_kind;
    assign result.length_ok        = buf_reg[rd_ptr_reg].length_ok;
    assign result.event_pid        = buf_reg[rd_ptr_reg].event_pid;
    assign result.syscall_number   = buf_reg[rd_ptr_reg].syscall_number;
    assign result.previous_pid     = buf_reg[rd_ptr_reg].previous_pid;
    assign result.previous_running = buf_reg[rd_ptr_reg].previous_running;
    assign result.incoming_pid     = buf_reg[rd_ptr_reg].incoming_pid;
    assign result.woken_pid        = buf_reg[rd_ptr_reg].woken_pid;
    assign result.wake_target_cpu  = buf_reg[rd_ptr_reg].wake_target_cpu;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result buffer count overflow");

    a_invalid_ends_page: assert property (@(posedge clk) disable iff (!rst_n)
        (push && emit_invalid) |=> (phase_reg == PH_IDLE))
        else $error("page not closed after invalid header");

    a_pos_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        data_phase |-> (bp_reg < pdb_reg))
        else $error("byte position past data end while decoding");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !push)
        else $error("result pushed into full buffer");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the trace ring page decoder: random paced pages, decode prediction.
module testbench;
    import trpd_pkg::*;

    localparam int          LIMIT_CYCLES   = 400000;
    localparam int          PHASE_WORDS    = 200;
    localparam logic [31:0] DATA_MAX       = 32'd4080;
    localparam logic [4:0]  TYPE_DATA_LEN  = 5'd0;
    localparam logic [4:0]  TYPE_INVALID   = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HEADER, ST_RECORD, ST_LEN_DATA, ST_LEN_PAD, ST_EXTEND, ST_PAYLOAD, ST_SKIP
    } decode_state_t;

    typedef struct packed {
        logic [31:0] word;
        logic        start;
    } page_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  write_enable;
    logic [CFG_IDX_W-1:0]  write_index;
    logic [CFG_DATA_W-1:0] write_data;

    trpd_page_if   page_ch();
    trpd_result_if result_ch();

    trace_ring_page_decoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .page         (page_ch),
        .result       (result_ch)
    );

    always #4 clk = ~clk;

    // decoder shadow state and register copies
    logic [7:0]    cfg_cpu;
    logic [15:0]   cfg_exit_id, cfg_enter_id, cfg_switch_id, cfg_wakeup_id;
    decode_state_t dec_state     = ST_IDLE;
    logic [1:0]    hdr_index     = '0;
    logic [12:0]   data_bytes    = '0;
    logic [12:0]   byte_pos      = '0;
    logic [63:0]   run_time      = '0;
    logic [26:0]   pending_delta = '0;
    logic [31:0]   bytes_left    = '0;
    logic [31:0]   rec_len       = '0;
    logic [4:0]    word_idx      = '0;
    held_t         held          = '0;

    page_word_t  page_words[$];
    result_t     expected_events[$];
    logic [31:0] page_body[$];
    int          words_queued;
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          send_gap    = 0;
    int          send_burst  = 0;
    int          ready_hold  = 0;
    int          ready_roll;
    page_word_t  next_word;
    bit          have_event;
    result_t     predicted, want;

    function automatic result_t record_result();
        result_t r;
        r = '0;
        r.timestamp_ns = run_time;
        r.ring_cpu     = cfg_cpu;
        r.event_pid    = held.pid;
        if (held.ev_type == cfg_exit_id) begin
            r.event_kind     = KIND_EXIT;
            r.length_ok      = rec_len == LEN_EXIT;
            r.syscall_number = held.number;
        end else if (held.ev_type == cfg_enter_id) begin
            r.event_kind     = KIND_ENTER;
            r.length_ok      = rec_len == LEN_ENTER;
            r.syscall_number = held.number;
        end else if (held.ev_type == cfg_switch_id) begin
            r.event_kind       = KIND_SWITCH;
            r.length_ok        = rec_len == LEN_SWITCH;
            r.previous_pid     = held.outgoing_pid;
            r.previous_running = held.prev_zero;
            r.incoming_pid     = held.incoming_pid;
        end else if (held.ev_type == cfg_wakeup_id) begin
            r.event_kind      = KIND_WAKEUP;
            r.length_ok       = rec_len == LEN_WAKEUP;
            r.woken_pid       = held.woken_pid;
            r.wake_target_cpu = held.target;
        end else begin
            r.event_kind = KIND_UNKNOWN;
            r.length_ok  = rec_len == LEN_UNKNOWN;
        end
        return r;
    endfunction

    // returns 1 when the record is empty and completes at once
    function automatic bit open_record(input logic [31:0] len);
        held           = '0;
        held.prev_zero = 1'b1;
        word_idx       = '0;
        rec_len        = len;
        bytes_left     = len;
        dec_state      = (len == 0) ? ST_RECORD : ST_PAYLOAD;
        return len == 0;
    endfunction

    function automatic void capture_field(input logic [31:0] w);
        case (word_idx)
            PW_TYPE:     held.ev_type = w[15:0];
            PW_PID:      held.pid = w;
            PW_NUM_LO:   held.number[31:0] = w;
            PW_NUM_HI:   held.number[63:32] = w;
            PW_PREV_PID:
            begin
                held.outgoing_pid = w;
                held.woken_pid    = w;
            end
            PW_STATE_LO: held.prev_zero = held.prev_zero && (w == 0);
            PW_STATE_HI:
            begin
                held.prev_zero = held.prev_zero && (w == 0);
                held.target    = w;
            end
            PW_NEXT_PID: held.incoming_pid = w;
            default:
            begin
            end
        endcase
    endfunction

    task automatic decode_word(input logic [31:0] w, input logic start, output bit got,
                               output result_t res);
        logic [12:0] avail;
        logic [4:0]  tl;
        logic [26:0] d;
        logic [31:0] nbytes, step, mask;
        got = 1'b0;
        res = '0;
        tl  = w[4:0];
        d   = w[31:5];
        if (start) begin
            run_time  = {32'd0, w};
            hdr_index = 2'd1;
            dec_state = ST_HEADER;
        end else if (dec_state == ST_HEADER) begin
            if (hdr_index == 2'd1) begin
                run_time[63:32] = w;
            end else if (hdr_index == 2'd2) begin
                data_bytes = (w < DATA_MAX) ? w[12:0] : DATA_MAX[12:0];
            end else begin
                if (w != 0)
                    data_bytes = DATA_MAX[12:0];
                byte_pos  = '0;
                dec_state = (data_bytes != 0) ? ST_RECORD : ST_IDLE;
            end
            hdr_index = hdr_index + 2'd1;
        end else if (dec_state != ST_IDLE) begin
            avail = (data_bytes > byte_pos) ? data_bytes - byte_pos : 13'd0;
            step  = (bytes_left < 4) ? bytes_left : 32'd4;
            case (dec_state)
                ST_RECORD:
                begin
                    if (tl == TYPE_DATA_LEN) begin
                        pending_delta = d;
                        dec_state     = ST_LEN_DATA;
                    end else if (tl <= TYPE_DATA_MAX) begin
                        run_time = run_time + d;
                        if (open_record({25'd0, tl, 2'b00})) begin
                            res = record_result();
                            got = 1'b1;
                        end
                    end else if (tl == TYPE_PADDING) begin
                        if (d == 0) begin
                            dec_state = ST_IDLE;
                        end else begin
                            pending_delta = d;
                            dec_state     = ST_LEN_PAD;
                        end
                    end else if (tl == TYPE_TIME_EXTEND) begin
                        pending_delta = d;
                        dec_state     = ST_EXTEND;
                    end else begin
                        res.timestamp_ns = run_time;
                        res.ring_cpu     = cfg_cpu;
                        res.event_kind   = KIND_INVALID;
                        got              = 1'b1;
                        dec_state        = ST_IDLE;
                    end
                end
                ST_LEN_DATA:
                begin
                    run_time = run_time + pending_delta;
                    if (open_record((w >= 4) ? w - 4 : 32'd0)) begin
                        res = record_result();
                        got = 1'b1;
                    end
                end
                ST_LEN_PAD:
                begin
                    run_time   = run_time + pending_delta;
                    bytes_left = (w >= 4) ? w - 4 : 32'd0;
                    dec_state  = (bytes_left != 0) ? ST_SKIP : ST_RECORD;
                end
                ST_EXTEND:
                begin
                    run_time  = run_time + ({32'd0, w} << DELTA_BITS) + pending_delta;
                    dec_state = ST_RECORD;
                end
                ST_SKIP:
                begin
                    bytes_left = bytes_left - step;
                    if (bytes_left == 0)
                        dec_state = ST_RECORD;
                end
                ST_PAYLOAD:
                begin
                    nbytes = step;
                    if ({19'd0, avail} < nbytes)
                        nbytes = {19'd0, avail};
                    mask = (nbytes >= 4) ? 32'hFFFF_FFFF : (32'd1 << (nbytes * 8)) - 1;
                    capture_field(w & mask);
                    bytes_left = bytes_left - step;
                    if (word_idx < PW_LAST)
                        word_idx = word_idx + 5'd1;
                    if (bytes_left == 0) begin
                        res       = record_result();
                        got       = 1'b1;
                        dec_state = ST_RECORD;
                    end
                end
                default: dec_state = ST_IDLE;
            endcase
            byte_pos = byte_pos + 13'd4;
            if (dec_state != ST_IDLE && byte_pos >= data_bytes) begin
                if (dec_state == ST_PAYLOAD && !got) begin
                    res = record_result();
                    got = 1'b1;
                end
                dec_state = ST_IDLE;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (send_burst > 0) begin
            send_burst--;
            return 0;
        end
        if (roll < 3) begin
            send_burst = $urandom_range(30, 150);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 2);
        if (roll < 97)
            return $urandom_range(3, 8);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            page_ch.valid      <= 1'b0;
            page_ch.word       <= '0;
            page_ch.page_start <= 1'b0;
        end else if (!page_ch.valid || page_ch.ready) begin
            if (send_gap > 0 || page_words.size() == 0) begin
                page_ch.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end else begin
                next_word           = page_words.pop_front();
                page_ch.valid      <= 1'b1;
                page_ch.word       <= next_word.word;
                page_ch.page_start <= next_word.start;
                send_gap            = pick_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 55) begin
                result_ch.ready <= 1'b1;
                ready_hold       = $urandom_range(0, 12);
            end else if (ready_roll < 62) begin
                result_ch.ready <= 1'b1;
                ready_hold       = $urandom_range(50, 200);
            end else if (ready_roll < 92) begin
                result_ch.ready <= 1'b0;
                ready_hold       = $urandom_range(0, 2);
            end else begin
                result_ch.ready <= 1'b0;
                ready_hold       = $urandom_range(5, 30);
            end
        end
    end

    // monitor: predict on accepted words, check accepted results
    always @(posedge clk) begin
        if (rst_n) begin
            if (page_ch.valid && page_ch.ready) begin
                decode_word(page_ch.word, page_ch.page_start, have_event, predicted);
                if (have_event)
                    expected_events.push_back(predicted);
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result kind %0d ts %h", $time,
                             result_ch.event_kind, result_ch.timestamp_ns);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("timestamp_ns", want.timestamp_ns, result_ch.timestamp_ns);
                    check_field("ring_cpu", want.ring_cpu, result_ch.ring_cpu);
                    check_field("event_kind", want.event_kind, result_ch.event_kind);
                    check_field("length_ok", want.length_ok, result_ch.length_ok);
                    check_field("event_pid", want.event_pid, result_ch.event_pid);
                    check_field("syscall_number", want.syscall_number,
                                result_ch.syscall_number);
                    check_field("previous_pid", want.previous_pid, result_ch.previous_pid);
                    check_field("previous_running", want.previous_running,
                                result_ch.previous_running);
                    check_field("incoming_pid", want.incoming_pid, result_ch.incoming_pid);
                    check_field("woken_pid", want.woken_pid, result_ch.woken_pid);
                    check_field("wake_target_cpu", want.wake_target_cpu,
                                result_ch.wake_target_cpu);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_word(input logic [31:0] w, input logic start);
        page_word_t pw;
        pw.word  = w;
        pw.start = start;
        page_words.push_back(pw);
        words_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge clk);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        case (idx)
            CFG_CPU_ID:    cfg_cpu = data[7:0];
            CFG_EXIT_ID:   cfg_exit_id = data;
            CFG_ENTER_ID:  cfg_enter_id = data;
            CFG_SWITCH_ID: cfg_switch_id = data;
            CFG_WAKEUP_ID: cfg_wakeup_id = data;
            default:
            begin
            end
        endcase
        @(posedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (page_words.size() != 0 || page_ch.valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input int setting);
        logic [15:0] cpu, ex, en, sw, wk;
        case (setting)
            0: {cpu, ex, en, sw, wk} = {16'hFFFF, 16'h0000, 16'hFFFF, SWITCH_ID_RESET,
                                        WAKEUP_ID_RESET};
            1: {cpu, ex, en, sw, wk} = {16'h0000, 16'h1234, 16'h1234, 16'h1234, 16'h1234};
            2: {cpu, ex, en, sw, wk} = {16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom)};
            3: {cpu, ex, en, sw, wk} = {16'h0080, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002};
            default: {cpu, ex, en, sw, wk} = {16'h007F, EXIT_ID_RESET, ENTER_ID_RESET,
                                              SWITCH_ID_RESET, WAKEUP_ID_RESET};
        endcase
        write_reg(CFG_CPU_ID, cpu);
        write_reg(CFG_EXIT_ID, ex);
        write_reg(CFG_ENTER_ID, en);
        write_reg(CFG_SWITCH_ID, sw);
        write_reg(CFG_WAKEUP_ID, wk);
    endtask

    task automatic pick_event(output logic [15:0] ev_type, output int nbytes);
        case ($urandom_range(0, 9))
            0, 1:    begin ev_type = cfg_exit_id;   nbytes = LEN_EXIT;    end
            2, 3:    begin ev_type = cfg_enter_id;  nbytes = LEN_ENTER;   end
            4, 5:    begin ev_type = cfg_switch_id; nbytes = LEN_SWITCH;  end
            6, 7:    begin ev_type = cfg_wakeup_id; nbytes = LEN_WAKEUP;  end
            default: begin ev_type = 16'($urandom); nbytes = LEN_UNKNOWN; end
        endcase
    endtask

    task automatic add_payload(input int nbytes, input logic [15:0] ev_type);
        logic [31:0] w;
        for (int i = 0; i < (nbytes + 3) / 4; i++) begin
            w = $urandom;
            if (i == PW_TYPE)
                w[15:0] = ev_type;
            else if ((i == PW_STATE_LO || i == PW_STATE_HI) && $urandom_range(0, 2) != 0)
                w = '0;
            page_body.push_back(w);
        end
    endtask

    task automatic add_record(output bit ends);
        int          sel, nbytes;
        logic [26:0] d;
        logic [15:0] ev_type;
        logic [31:0] len_word;
        ends = 1'b0;
        d    = ($urandom_range(0, 3) == 0) ? 27'($urandom) : 27'($urandom_range(0, 2000));
        sel  = $urandom_range(0, 99);
        if (sel < 40) begin
            pick_event(ev_type, nbytes);
            if ($urandom_range(0, 4) == 0)
                nbytes = 4 * $urandom_range(1, 28);
            page_body.push_back({d, 5'(nbytes / 4)});
            add_payload(nbytes, ev_type);
        end else if (sel < 65) begin
            pick_event(ev_type, nbytes);
            sel = $urandom_range(0, 19);
            if (sel < 4)
                nbytes = $urandom_range(0, 160);
            len_word = nbytes + 4;
            if (sel == 4 || sel == 5) begin
                len_word = $urandom_range(0, 3);
                nbytes   = 0;
            end else if (sel == 6) begin
                len_word = 32'hFFFF_FFFF;
                nbytes   = 0;
            end
            page_body.push_back({d, TYPE_DATA_LEN});
            page_body.push_back(len_word);
            add_payload(nbytes, ev_type);
        end else if (sel < 73) begin
            if (d == 0)
                d = 27'd1;
            len_word = $urandom_range(0, 1) ? 4 * $urandom_range(1, 6) : $urandom_range(0, 30);
            page_body.push_back({d, TYPE_PADDING});
            page_body.push_back(len_word);
            if (len_word > 4)
                for (int i = 0; i < (len_word - 1) / 4; i++)
                    page_body.push_back($urandom);
        end else if (sel < 83) begin
            page_body.push_back({d, TYPE_TIME_EXTEND});
            page_body.push_back($urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : $urandom);
        end else if (sel < 88) begin
            page_body.push_back({27'd0, TYPE_PADDING});
            ends = 1'b1;
        end else if (sel < 91) begin
            page_body.push_back({d, TYPE_INVALID});
            ends = 1'b1;
        end else begin
            page_body.push_back($urandom);
        end
    endtask

    task automatic build_page();
        int          sel, nrec, keep;
        bit          closed;
        logic [31:0] body_bytes, len_hi;
        page_body.delete();
        closed = 1'b0;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12)) page_body.push_back($urandom);
        end else begin
            nrec = $urandom_range(1, 8);
            for (int i = 0; i < nrec && !closed; i++)
                add_record(closed);
        end
        len_hi = '0;
        sel    = $urandom_range(0, 99);
        if (sel < 70)
            body_bytes = page_body.size() * 4;
        else if (sel < 80)
            body_bytes = $urandom_range(0, page_body.size() * 4);
        else if (sel < 85)
            body_bytes = '0;
        else if (sel < 92)
            body_bytes = $urandom_range(0, 1) ? 32'($urandom_range(4080, 5000)) : 32'hFFFF_FFFF;
        else begin
            body_bytes = page_body.size() * 4;
            len_hi     = $urandom | 32'd1;
        end
        push_word($urandom, 1'b1);
        push_word($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom, 1'b0);
        push_word(body_bytes, 1'b0);
        push_word(len_hi, 1'b0);
        keep = page_body.size();
        if ($urandom_range(0, 9) == 0)
            keep = $urandom_range(0, page_body.size());
        for (int i = 0; i < keep; i++)
            push_word(page_body[i], 1'b0);
        if (keep == page_body.size())
            repeat ($urandom_range(0, 2)) push_word($urandom, 1'b0);
    endtask

    initial begin
        rst_n              = 1'b0;
        write_enable       = 1'b0;
        write_index        = CFG_CPU_ID;
        write_data         = '0;
        cfg_cpu            = '0;
        cfg_exit_id        = EXIT_ID_RESET;
        cfg_enter_id       = ENTER_ID_RESET;
        cfg_switch_id      = SWITCH_ID_RESET;
        cfg_wakeup_id      = WAKEUP_ID_RESET;
        words_queued       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // stray word before any page, then a full-range page ending on an invalid header
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word({27'h7FF_FFFF, 5'd6}, 1'b0);
        push_word({16'hFFFF, EXIT_ID_RESET}, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word({27'h7FF_FFFF, TYPE_TIME_EXTEND}, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word({27'd3, 5'd2}, 1'b0);
        push_word(32'hFFFF_ABCD, 1'b0);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word({27'd1, TYPE_INVALID}, 1'b0);
        // data ends right after the length word: record emitted with zero fields
        push_word(32'h0000_0000, 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'd8, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word({27'd5, TYPE_DATA_LEN}, 1'b0);
        push_word(32'd68, 1'b0);
        // empty page
        push_word(32'h0000_1000, 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        wait_drained();

        for (int setting = 0; setting < 5; setting++) begin
            configure(setting);
            words_queued = 0;
            while (words_queued < PHASE_WORDS)
                build_page();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (expected_events.size() != 0)
            $display("%0t: expected %0d more results, actual 0", $time,
                     expected_events.size());
        if (mismatches == 0 && expected_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
